[design/cspw_pkg.sv]
// Package for the clipped span byte mask writer.
// Holds the payload structs, the register indexes, the mask constants and the
// command and status structs that join the controller to the datapath.
package cspw_pkg;

	// Field widths fixed by the register and payload definitions.
	localparam int unsigned FW_W      = 10; // frame width register
	localparam int unsigned FH_W      = 9;  // frame height register
	localparam int unsigned STRIDE_W  = 7;  // row stride register
	localparam int unsigned MODE_W    = 2;  // drawing mode register
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 10;
	localparam int unsigned COORD_W   = 12;
	localparam int unsigned OFFSET_W  = 14;
	localparam int unsigned MASK_W    = 8;
	// Byte column within a row: frame columns divided by eight.
	localparam int unsigned BCOL_W    = FW_W - 3;
	// Row number used for addressing once the row has passed the clip test.
	localparam int unsigned ROW_W     = 8;
	localparam int unsigned ROWBASE_W = ROW_W + STRIDE_W;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DRAW_MODE    = 2'd3;

	// Reset values of the registers.
	localparam logic [FW_W-1:0]     RST_FRAME_WIDTH  = 10'd400;
	localparam logic [FH_W-1:0]     RST_FRAME_HEIGHT = 9'd240;
	localparam logic [STRIDE_W-1:0] RST_ROW_STRIDE   = 7'd50;
	localparam logic [MODE_W-1:0]   RST_DRAW_MODE    = 2'd0;

	localparam logic [MASK_W-1:0] FULL_MASK = 8'hFF;

	typedef struct packed {
		logic signed [COORD_W-1:0] start_column;
		logic signed [COORD_W-1:0] row_index;
		logic        [COORD_W-1:0] span_width;
	} in_item_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] byte_offset;
		logic [MASK_W-1:0]   pixel_mask;
		logic [MODE_W-1:0]   mode_out;
		logic                last_write;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load; // capture the request
		logic clip; // register the clipped span
		logic emit; // load the next byte write into the output register
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic drop;     // the captured request leaves nothing visible
		logic at_last;  // the current byte is the final one of the span
		logic out_free; // the output register can take a write this cycle
	} ctrl_status_t;

endpackage

[design/cspw_ctrl.sv]
// Controller state machine of the clipped span byte mask writer.
// Sequences capture, clip and one byte write per cycle while the output register is free; uses cspw_pkg.
module cspw_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  cspw_pkg::ctrl_status_t status,
	output cspw_pkg::ctrl_cmd_t    cmd
);
	import cspw_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CLIP = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CLIP;
				end
			end
			ST_CLIP: begin
				cmd.clip = 1'b1;
				state_d  = status.drop ? ST_IDLE : ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.at_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[design/cspw_datapath.sv]
// Datapath of the clipped span byte mask writer: registers, clip logic,
// byte column counter, mask generation and the output register; uses cspw_pkg.
module cspw_datapath #(
	parameter int unsigned MAX_WIDTH  = 512,
	parameter int unsigned MAX_HEIGHT = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [cspw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cspw_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  cspw_pkg::in_item_t                  in_data,
	input  cspw_pkg::ctrl_cmd_t                 cmd,
	output cspw_pkg::ctrl_status_t              status,
	output logic                                out_valid,
	input  logic                                out_ready,
	output cspw_pkg::out_item_t                 out_data
);
	import cspw_pkg::*;

	localparam logic [FW_W-1:0] MaxW = FW_W'(MAX_WIDTH);
	localparam logic [FH_W-1:0] MaxH = FH_W'(MAX_HEIGHT);
	localparam int unsigned SW = OFFSET_W; // signed working width of the clip

	// Configuration registers.
	logic [FW_W-1:0]     frame_width_q;
	logic [FH_W-1:0]     frame_height_q;
	logic [STRIDE_W-1:0] row_stride_q;
	logic [MODE_W-1:0]   draw_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
			row_stride_q   <= RST_ROW_STRIDE;
			draw_mode_q    <= RST_DRAW_MODE;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				REG_ROW_STRIDE:   row_stride_q   <= cfg_data[STRIDE_W-1:0];
				REG_DRAW_MODE:    draw_mode_q    <= cfg_data[MODE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Captured request.
	logic signed [COORD_W-1:0] x_q;
	logic signed [COORD_W-1:0] y_q;
	logic        [COORD_W-1:0] w_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= in_data.start_column;
			y_q <= in_data.row_index;
			w_q <= in_data.span_width;
		end
	end

	// Clip: the span runs over columns x0 .. e-1 of the clamped frame.
	logic [FW_W-1:0]          fw;
	logic [FH_W-1:0]          fh;
	logic [FW_W-1:0]          wc;
	logic signed [SW-1:0]     s_sum;
	logic signed [SW-1:0]     fw_s;
	logic signed [SW-1:0]     e_col;
	logic signed [SW-1:0]     x0;
	logic signed [SW-1:0]     em1;
	logic                     y_bad;
	logic [3:0]               rg_full;

	always_comb begin
		fw      = (frame_width_q > MaxW) ? MaxW : frame_width_q;
		fh      = (frame_height_q > MaxH) ? MaxH : frame_height_q;
		wc      = (w_q > {{(COORD_W-FW_W){1'b0}}, fw}) ? fw : w_q[FW_W-1:0];
		s_sum   = {{(SW-COORD_W){x_q[COORD_W-1]}}, x_q}
		          + $signed({{(SW-FW_W){1'b0}}, wc});
		fw_s    = $signed({{(SW-FW_W){1'b0}}, fw});
		e_col   = (s_sum > fw_s) ? fw_s : s_sum;
		x0      = x_q[COORD_W-1] ? '0 : {{(SW-COORD_W){1'b0}}, x_q};
		em1     = e_col - SW'(1);
		y_bad   = y_q[COORD_W-1]
		          | ($signed({y_q[COORD_W-1], y_q})
		             >= $signed({{(COORD_W+1-FH_W){1'b0}}, fh}));
		rg_full = 4'd8 - {1'b0, e_col[2:0]};
	end

	assign status.drop = y_bad | (e_col <= x0);

	// Clipped span, held while its byte writes go out.
	logic [BCOL_W-1:0]    col_q;
	logic [BCOL_W-1:0]    first_q;
	logic [BCOL_W-1:0]    lastb_q;
	logic [MASK_W-1:0]    lmask_q;
	logic [MASK_W-1:0]    rmask_q;
	logic [ROWBASE_W-1:0] row_base_q;

	always_ff @(posedge clk) begin
		if (cmd.clip) begin
			first_q    <= x0[FW_W-1:3];
			lastb_q    <= em1[FW_W-1:3];
			lmask_q    <= FULL_MASK >> x0[2:0];
			rmask_q    <= FULL_MASK << rg_full[2:0];
			row_base_q <= ROWBASE_W'(y_q[ROW_W-1:0]) * ROWBASE_W'(row_stride_q);
		end
	end

	// Byte column counter.
	always_ff @(posedge clk) begin
		if (cmd.clip) begin
			col_q <= x0[FW_W-1:3];
		end else if (cmd.emit) begin
			col_q <= col_q + BCOL_W'(1);
		end
	end

	logic                 is_first;
	logic                 is_last;
	logic [MASK_W-1:0]    mask_d;
	logic [ROWBASE_W-1:0] offset_sum;

	always_comb begin
		is_first   = (col_q == first_q);
		is_last    = (col_q == lastb_q);
		mask_d     = (is_first ? lmask_q : FULL_MASK) & (is_last ? rmask_q : FULL_MASK);
		offset_sum = row_base_q + {{(ROWBASE_W-BCOL_W){1'b0}}, col_q};
	end

	assign status.at_last = is_last;

	// Output register.
	logic      out_valid_q;
	out_item_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.byte_offset <= offset_sum[OFFSET_W-1:0];
			out_q.pixel_mask  <= mask_d;
			out_q.mode_out    <= draw_mode_q;
			out_q.last_write  <= is_last;
		end
	end

	assign status.out_free = ~out_valid_q | out_ready;
	assign out_valid       = out_valid_q;
	assign out_data        = out_q;

endmodule

[design/clipped_span_byte_mask_writer_core.sv]
// Top level of the clipped span byte mask writer.
// Joins cspw_ctrl and cspw_datapath; types and constants come from cspw_pkg.
//
//  Channel  Signals                           Dir  Content
//  -------  --------------------------------  ---  -------------------------------
//  in       in_valid, in_ready, in_data       in   start column, row, span width
//  out      out_valid, out_ready, out_data    out  byte offset, mask, mode, last flag
//  cfg      cfg_wr_en, cfg_index, cfg_data    in   frame width, height, stride, mode
//
// A request is taken in the idle state, clipped in the following cycle, and then
// gives one byte write per cycle from the byte column counter, one for each byte
// the span touches (at most 64 with the default MAX_WIDTH); a dropped span gives
// none. Back-pressure on the output holds the counter, and a new request is
// taken as soon as the last write sits in the output register, even before that
// transfer completes. Reset clears the state machine and the output valid flag and
// loads the register defaults (400 columns, 240 rows, stride 50, mode 0).
module clipped_span_byte_mask_writer_core #(
	parameter int unsigned MAX_WIDTH  = 512,
	parameter int unsigned MAX_HEIGHT = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [cspw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cspw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  cspw_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output cspw_pkg::out_item_t             out_data
);
	import cspw_pkg::*;

	// The controller only sees what it needs to sequence a span: whether the
	// request survived clipping, whether the current byte closes the span, and
	// whether the output register can take another write.
	ctrl_cmd_t    cmd;
	ctrl_status_t status;

	cspw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the registers, the clip arithmetic, the row base
	// multiply, the mask generation and the output register that parts the
	// byte write sequence from the consumer.
	cspw_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

[verif/span_write_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the clipped span byte mask writer. It follows the register
// writes, predicts the byte writes of every span request and checks each output
// transfer against them. Depends on cspw_pkg for payload types and register indexes.
module span_write_checker #(
	parameter int unsigned MAX_WIDTH  = 512,
	parameter int unsigned MAX_HEIGHT = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [cspw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cspw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  cspw_pkg::in_item_t              in_data,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  cspw_pkg::out_item_t             out_data,
	output int                              pending_writes,
	output int                              mismatch_count
);
	import cspw_pkg::*;

	logic [FW_W-1:0]     frame_width;
	logic [FH_W-1:0]     frame_height;
	logic [STRIDE_W-1:0] row_stride;
	logic [MODE_W-1:0]   draw_mode;

	out_item_t expected_writes[$];
	out_item_t due_write;

	initial begin
		pending_writes = 0;
		mismatch_count = 0;
	end

	function automatic void queue_write(int offset, int mask, bit last);
		out_item_t item;
		item.byte_offset = offset[OFFSET_W-1:0];
		item.pixel_mask  = mask[MASK_W-1:0];
		item.mode_out    = draw_mode;
		item.last_write  = last;
		expected_writes.push_back(item);
	endfunction

	// Clip the span to the frame, then walk its bytes from left to right.
	function automatic void predict_span_writes(in_item_t req);
		int fw, fh, col, row, width, row_base, end_col;
		int first_byte, last_byte, lead_skip, tail_skip, c;
		fw = (frame_width > MAX_WIDTH) ? int'(MAX_WIDTH) : int'(frame_width);
		fh = (frame_height > MAX_HEIGHT) ? int'(MAX_HEIGHT) : int'(frame_height);
		col = $signed(req.start_column);
		row = $signed(req.row_index);
		width = int'(req.span_width);
		if (width > fw)
			width = fw;
		if (col < 0) begin
			if (-col >= width)
				return;
			width += col;
			col = 0;
		end else if (col >= fw) begin
			return;
		end
		if (row < 0 || row >= fh)
			return;
		if (col + width > fw)
			width = fw - col;
		if (width <= 0)
			return;

		row_base = row * int'(row_stride);
		end_col = col + width;
		first_byte = col >> 3;
		last_byte = end_col >> 3;
		lead_skip = col & 7;
		tail_skip = (8 - (end_col & 7)) & 7;

		if (first_byte == last_byte) begin
			queue_write(row_base + first_byte,
				((int'(FULL_MASK) >> (lead_skip + tail_skip)) << tail_skip) & int'(FULL_MASK),
				1'b1);
			return;
		end
		queue_write(row_base + first_byte, int'(FULL_MASK) >> lead_skip,
			(last_byte == first_byte + 1) && (tail_skip == 0));
		for (c = first_byte + 1; c < last_byte; c++)
			queue_write(row_base + c, int'(FULL_MASK), (c + 1 == last_byte) && (tail_skip == 0));
		if (tail_skip != 0)
			queue_write(row_base + last_byte, (int'(FULL_MASK) << tail_skip) & int'(FULL_MASK), 1'b1);
	endfunction

	// Output check first, then prediction, then register update: a request taken at
	// the same edge as a register write still sees the old settings.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width  = RST_FRAME_WIDTH;
			frame_height = RST_FRAME_HEIGHT;
			row_stride   = RST_ROW_STRIDE;
			draw_mode    = RST_DRAW_MODE;
			expected_writes.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_writes.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected byte write offset %0d mask %02h mode %0d last %0b",
							$realtime, out_data.byte_offset, out_data.pixel_mask,
							out_data.mode_out, out_data.last_write);
				end else begin
					due_write = expected_writes.pop_front();
					if (out_data.byte_offset !== due_write.byte_offset ||
					    out_data.pixel_mask !== due_write.pixel_mask ||
					    out_data.mode_out !== due_write.mode_out ||
					    out_data.last_write !== due_write.last_write) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"%0t: byte write mismatch: expected offset %0d mask %02h ",
								"mode %0d last %0b, got offset %0d mask %02h mode %0d last %0b"},
								$realtime, due_write.byte_offset, due_write.pixel_mask,
								due_write.mode_out, due_write.last_write,
								out_data.byte_offset, out_data.pixel_mask,
								out_data.mode_out, out_data.last_write);
					end
				end
			end
			if (in_valid && in_ready)
				predict_span_writes(in_data);
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_FRAME_WIDTH:  frame_width  = cfg_data[FW_W-1:0];
					REG_FRAME_HEIGHT: frame_height = cfg_data[FH_W-1:0];
					REG_ROW_STRIDE:   row_stride   = cfg_data[STRIDE_W-1:0];
					REG_DRAW_MODE:    draw_mode    = cfg_data[MODE_W-1:0];
					default: ;
				endcase
			end
		end
		pending_writes = expected_writes.size();
	end

endmodule

[verif/clipped_span_byte_mask_writer_core_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the clipped span byte mask writer: drives span requests,
// register writes and output back-pressure, and gives the verdict. Checking is
// done by span_write_checker; types and register indexes come from cspw_pkg.
module clipped_span_byte_mask_writer_core_tb;
	import cspw_pkg::*;

	localparam int unsigned MAX_WIDTH  = 512;
	localparam int unsigned MAX_HEIGHT = 256;
	// Generous watchdog: far beyond a run in which every span touches 64 bytes and
	// every byte write meets the longest receiver stall.
	localparam int unsigned CYCLE_LIMIT = 6_000_000;
	// A dropped span gives no byte write, so draining the predicted writes does not
	// show it; SETTLE_CYCLES quiet cycles are allowed before a register write.
	localparam int unsigned SETTLE_CYCLES = 80;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_item_t             out_data;

	int          pending_writes;
	int          mismatch_count;
	int unsigned cycle_count = 0;
	// When clear, neither side inserts gaps: the block runs flat out.
	bit          idle_en = 1'b1;
	// Frame size as last written, used to aim the random spans at the visible area.
	int          cur_fw;
	int          cur_fh;

	clipped_span_byte_mask_writer_core #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	span_write_checker #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) write_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.pending_writes (pending_writes),
		.mismatch_count (mismatch_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("clipped_span_byte_mask_writer_core_tb: FAIL");
		$finish;
	end

	// Mostly short pauses, now and then a long one.
	function automatic int pause_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			return $urandom_range(1, 3);
		else if (pick < 92)
			return $urandom_range(4, 8);
		else
			return $urandom_range(15, 40);
	endfunction

	function automatic int sender_gap();
		if (!idle_en || $urandom_range(0, 99) < 60)
			return 0;
		return pause_length();
	endfunction

	// Receiver: out_ready changes only at the falling edge. While idling is allowed,
	// about one cycle in five starts a stall of random length.
	initial begin : sink
		int stall;
		out_ready = 1'b0;
		stall = 0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				if (idle_en && $urandom_range(0, 99) < 20)
					stall = pause_length();
			end
		end
	end

	function automatic in_item_t make_span_req(int col, int row, int width);
		in_item_t req;
		req.start_column = col[COORD_W-1:0];
		req.row_index    = row[COORD_W-1:0];
		req.span_width   = width[COORD_W-1:0];
		return req;
	endfunction

	// A quarter of the requests are raw noise over the whole field ranges; the rest
	// are aimed at the visible frame with some straddling its edges, so that most
	// of them produce byte writes with every mask shape.
	function automatic in_item_t random_span();
		int fwe, fhe, col, row, width, pick;
		fwe = (cur_fw > MAX_WIDTH) ? MAX_WIDTH : cur_fw;
		fhe = (cur_fh > MAX_HEIGHT) ? MAX_HEIGHT : cur_fh;
		if (fwe == 0)
			fwe = 64;
		if (fhe == 0)
			fhe = 16;
		if ($urandom_range(0, 99) < 25)
			return make_span_req($urandom, $urandom, $urandom);

		pick = $urandom_range(0, 9);
		if (pick < 8)
			col = $urandom_range(0, fwe - 1);
		else if (pick == 8)
			col = 0 - int'($urandom_range(1, 24));
		else
			col = fwe - 4 + int'($urandom_range(0, 12));

		pick = $urandom_range(0, 19);
		if (pick < 18)
			row = $urandom_range(0, fhe - 1);
		else if (pick == 18)
			row = -1;
		else
			row = fhe + int'($urandom_range(0, 3));

		pick = $urandom_range(0, 99);
		if (pick < 40)
			width = $urandom_range(1, 16);
		else if (pick < 70)
			width = $urandom_range(1, fwe);
		else if (pick < 85)
			width = $urandom_range(17, 96);
		else
			width = $urandom_range(fwe, 4095);
		return make_span_req(col, row, width);
	endfunction

	// One request transfer. Valid goes up at a falling edge after an optional gap and
	// stays up, with the payload held, until the rising edge at which ready is seen.
	// It is left high on return so that a back-to-back request needs no lowering.
	task automatic send_span(in_item_t req);
		int gap;
		gap = sender_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Stop sending and wait until every predicted byte write has been transferred,
	// then let the given number of extra cycles pass.
	task automatic drain_results(int extra);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_writes != 0) @(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	// Registers are only written once the block has gone quiet.
	task automatic set_frame(int fw, int fh, int stride, int mode);
		drain_results(SETTLE_CYCLES);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data <= fw[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_index <= REG_FRAME_HEIGHT;
		cfg_data <= fh[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_index <= REG_ROW_STRIDE;
		cfg_data <= stride[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_index <= REG_DRAW_MODE;
		cfg_data <= mode[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cur_fw = fw & ((1 << FW_W) - 1);
		cur_fh = fh & ((1 << FH_W) - 1);
	endtask

	// One phase of random requests under a single register setting. In a phase of
	// 20 or more, the sender holds off half way through until the output has caught up.
	task automatic run_phase(int fw, int fh, int stride, int mode, int count, bit quiet);
		set_frame(fw, fh, stride, mode);
		idle_en <= !quiet;
		for (int i = 0; i < count; i++) begin
			if (count >= 20 && i == count / 2)
				drain_results(0);
			send_span(random_span());
		end
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_FRAME_WIDTH;
		cfg_data = '0;
		cur_fw = RST_FRAME_WIDTH;
		cur_fh = RST_FRAME_HEIGHT;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed requests under the reset settings: 400 columns, 240 rows,
		// stride 50, mode 0. Each covers a mask shape or a clipping case.
		send_span(make_span_req(0, 0, 1));         // lone leftmost pixel
		send_span(make_span_req(3, 0, 2));         // combined mask inside one byte
		send_span(make_span_req(7, 9, 1));         // rightmost pixel of a byte
		send_span(make_span_req(1, 10, 7));        // ends exactly on a byte boundary
		send_span(make_span_req(0, 0, 8));         // one whole aligned byte
		send_span(make_span_req(5, 1, 10));        // two partial bytes
		send_span(make_span_req(8, 2, 16));        // two whole bytes
		send_span(make_span_req(2, 3, 30));        // partial first byte, then full bytes
		send_span(make_span_req(0, 239, 400));     // whole bottom row
		send_span(make_span_req(0, 0, 4095));      // widest request, clamped
		send_span(make_span_req(-5, 4, 10));       // negative start, part visible
		send_span(make_span_req(-10, 4, 10));      // negative start eats the span
		send_span(make_span_req(-2048, 5, 4095));  // most negative start
		send_span(make_span_req(399, 6, 1));       // last visible column
		send_span(make_span_req(399, 6, 4095));    // cut at the right edge
		send_span(make_span_req(396, 11, 100));    // partial last byte, cut at the edge
		send_span(make_span_req(400, 6, 5));       // start on the frame width
		send_span(make_span_req(2047, 7, 5));      // largest start
		send_span(make_span_req(10, -1, 5));       // row just above the frame
		send_span(make_span_req(10, -2048, 5));    // most negative row
		send_span(make_span_req(10, 240, 5));      // row on the frame height
		send_span(make_span_req(10, 2047, 5));     // largest row
		send_span(make_span_req(10, 8, 0));        // zero width

		// Register settings, extremes first: the largest frame with the full 64-byte
		// span, the smallest frame, oversized frame registers with offsets that wrap,
		// zero width, zero height and zero stride.
		run_phase(512, 256, 64, 1, 60, 1'b0);
		run_phase(1, 1, 1, 2, 20, 1'b0);
		run_phase(1023, 511, 127, 3, 50, 1'b0);
		run_phase(0, 240, 50, 0, 10, 1'b0);
		run_phase(400, 0, 50, 1, 10, 1'b0);
		run_phase(300, 200, 0, 2, 40, 1'b1);
		run_phase(8, 3, 1, 3, 30, 1'b0);
		for (int k = 0; k < 4; k++)
			run_phase($urandom_range(1, 520), $urandom_range(1, 260), $urandom_range(0, 127),
				$urandom_range(0, 3), 50, k == 1);
		run_phase(400, 240, 50, 0, 30, 1'b0);

		// Everything sent: wait for the last byte writes and a little beyond, so that
		// a stray extra write would still be caught.
		drain_results(SETTLE_CYCLES);
		if (mismatch_count == 0 && pending_writes == 0) begin
			$display("clipped_span_byte_mask_writer_core_tb: PASS");
		end else begin
			$display("clipped_span_byte_mask_writer_core_tb: FAIL");
		end
		$finish;
	end

endmodule
